// ===== rtl/core/mnd_pkg.sv =====
// Shared constants, codes and control structs for the descriptor matcher.
`timescale 1ns / 1ps
package mnd_pkg;

  localparam int REQ_W      = 2;
  localparam int PT_IN_W    = 10;
  localparam int EL_IN_W    = 6;
  localparam int VAL_W      = 16;
  localparam int CNT_IN_W   = 11;
  localparam int ORD_W      = 10;
  localparam int TOT_W      = 11;
  localparam int DIST_W     = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int LEN_CFG_W  = 7;
  localparam int MINSIM_W   = 17;
  localparam int RATIO_W    = 16;

  // request codes
  localparam logic [REQ_W-1:0] REQ_LOAD_A = 2'd0;
  localparam logic [REQ_W-1:0] REQ_LOAD_B = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RUN    = 2'd2;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DESC_LEN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIM  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MUTUAL   = 2'd3;

  // reply kinds
  localparam logic KIND_RUN  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // register reset values
  localparam logic [LEN_CFG_W-1:0] DESC_LEN_RST = 7'd64;
  localparam logic [MINSIM_W-1:0]  MIN_SIM_RST  = 17'd0;
  localparam logic [RATIO_W-1:0]   RATIO_RST    = 16'd31130;
  localparam logic                 MUTUAL_RST   = 1'b1;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic run_latch;
    logic read_latch;
    logic clr_i;
    logic inc_i;
    logic clr_j;
    logic inc_j;
    logic dot_start;
    logic row_init;
    logic row_cmp;
    logic row_wr;
    logic col_init;
    logic col_cmp;
    logic col_wr;
    logic fin_chk;
    logic reply_run;
    logic reply_read;
  } mnd_cmd_t;

  typedef struct packed {
    logic dot_done;
    logic i_last;
    logic j_last;
    logic empty;
    logic mutual;
    logic out_free;
  } mnd_status_t;

endpackage

// ===== rtl/core/mnd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mnd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/mnd_ctrl.sv =====
// Sequencer for loads, row scan, column scan, match filtering and replies.
`timescale 1ns / 1ps
module mnd_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [mnd_pkg::REQ_W-1:0]  req_type_i,
  input  mnd_pkg::mnd_status_t       status_i,
  output mnd_pkg::mnd_cmd_t          cmd_o
);
  import mnd_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_RUN_CHK,
    S_R_INIT, S_R_DS, S_R_DW, S_R_CMP, S_R_WR,
    S_C_INIT, S_C_DS, S_C_DW, S_C_CMP, S_C_WR,
    S_F_RD, S_F_RD2, S_F_CHK,
    S_RUN_REPLY, S_RD_REPLY
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_type_i inside {REQ_LOAD_A, REQ_LOAD_B}) begin
            cmd_o.load_a = (req_type_i == REQ_LOAD_A);
            cmd_o.load_b = (req_type_i == REQ_LOAD_B);
          end else if (req_type_i == REQ_RUN) begin
            cmd_o.run_latch = 1'b1;
            state_d = S_RUN_CHK;
          end else begin
            cmd_o.read_latch = 1'b1;
            state_d = S_RD_REPLY;
          end
        end
      end
      S_RUN_CHK: begin
        cmd_o.clr_i = 1'b1;
        state_d = status_i.empty ? S_RUN_REPLY : S_R_INIT;
      end
      S_R_INIT: begin
        cmd_o.clr_j    = 1'b1;
        cmd_o.row_init = 1'b1;
        state_d = S_R_DS;
      end
      S_R_DS: begin
        cmd_o.dot_start = 1'b1;
        state_d = S_R_DW;
      end
      S_R_DW: begin
        if (status_i.dot_done) state_d = S_R_CMP;
      end
      S_R_CMP: begin
        cmd_o.row_cmp = 1'b1;
        if (status_i.j_last) begin
          state_d = S_R_WR;
        end else begin
          cmd_o.inc_j = 1'b1;
          state_d = S_R_DS;
        end
      end
      S_R_WR: begin
        cmd_o.row_wr = 1'b1;
        if (!status_i.i_last) begin
          cmd_o.inc_i = 1'b1;
          state_d = S_R_INIT;
        end else if (status_i.mutual) begin
          cmd_o.clr_j = 1'b1;
          state_d = S_C_INIT;
        end else begin
          cmd_o.clr_i = 1'b1;
          state_d = S_F_RD;
        end
      end
      S_C_INIT: begin
        cmd_o.clr_i    = 1'b1;
        cmd_o.col_init = 1'b1;
        state_d = S_C_DS;
      end
      S_C_DS: begin
        cmd_o.dot_start = 1'b1;
        state_d = S_C_DW;
      end
      S_C_DW: begin
        if (status_i.dot_done) state_d = S_C_CMP;
      end
      S_C_CMP: begin
        cmd_o.col_cmp = 1'b1;
        if (status_i.i_last) begin
          state_d = S_C_WR;
        end else begin
          cmd_o.inc_i = 1'b1;
          state_d = S_C_DS;
        end
      end
      S_C_WR: begin
        cmd_o.col_wr = 1'b1;
        if (status_i.j_last) begin
          cmd_o.clr_i = 1'b1;
          state_d = S_F_RD;
        end else begin
          cmd_o.inc_j = 1'b1;
          state_d = S_C_INIT;
        end
      end
      S_F_RD:  state_d = S_F_RD2;
      S_F_RD2: state_d = S_F_CHK;
      S_F_CHK: begin
        cmd_o.fin_chk = 1'b1;
        if (status_i.i_last) begin
          state_d = S_RUN_REPLY;
        end else begin
          cmd_o.inc_i = 1'b1;
          state_d = S_F_RD;
        end
      end
      S_RUN_REPLY: begin
        if (status_i.out_free) begin
          cmd_o.reply_run = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_RD_REPLY: begin
        if (status_i.out_free) begin
          cmd_o.reply_read = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // a run never finishes in the cycle after it is taken
  a_run_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.run_latch |=> (state_q == S_RUN_CHK))
    else $error("run request did not start the sequence");

endmodule

// ===== rtl/core/mnd_dp.sv =====
// Datapath: descriptor stores, dot-product engine, scan registers, match store.
`timescale 1ns / 1ps
module mnd_dp #(
  parameter int MAX_POINTS   = 1024,
  parameter int MAX_DESC_LEN = 64,
  parameter int ELEM_BITS    = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mnd_pkg::mnd_cmd_t             cmd_i,
  output mnd_pkg::mnd_status_t          status_o,
  input  logic                          cfg_we_i,
  input  logic [mnd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mnd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [mnd_pkg::PT_IN_W-1:0]   point_index_i,
  input  logic [mnd_pkg::EL_IN_W-1:0]   elem_index_i,
  input  logic [mnd_pkg::VAL_W-1:0]     elem_value_i,
  input  logic [mnd_pkg::CNT_IN_W-1:0]  count_a_i,
  input  logic [mnd_pkg::CNT_IN_W-1:0]  count_b_i,
  input  logic [mnd_pkg::ORD_W-1:0]     match_ordinal_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          reply_kind_o,
  output logic [mnd_pkg::TOT_W-1:0]     match_total_o,
  output logic                          found_o,
  output logic [mnd_pkg::PT_IN_W-1:0]   row_point_o,
  output logic [mnd_pkg::PT_IN_W-1:0]   col_point_o,
  output logic [mnd_pkg::DIST_W-1:0]    distance_o
);
  import mnd_pkg::*;

  localparam int PT_W   = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int LEN_W  = $clog2(MAX_DESC_LEN + 1);
  localparam int A_AW   = $clog2(MAX_POINTS * MAX_DESC_LEN);
  localparam int A_DEP  = MAX_POINTS * MAX_DESC_LEN;
  localparam int PROD_W = 2 * ELEM_BITS;
  localparam int ACC_W  = PROD_W + LEN_W;
  localparam int SIM_W  = (ACC_W - 15 > 18) ? ACC_W - 15 : 18;
  localparam int ACCX_W = SIM_W + 15;
  localparam int RP_W   = SIM_W + 17;
  localparam int ROW_W  = 1 + PT_W + 2 * SIM_W;
  localparam int COL_W  = 1 + PT_W;
  localparam int MW     = 2 * PT_W + DIST_W;
  localparam int WIDE_W = 13;

  localparam logic signed [SIM_W-1:0] SIM_NEG_ONE = SIM_W'(-32'sd32768);

  // configuration
  logic [LEN_CFG_W-1:0] len_cfg_q;
  logic [MINSIM_W-1:0]  minsim_q;
  logic [RATIO_W-1:0]   ratio_q;
  logic                 mutual_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_cfg_q <= DESC_LEN_RST;
      minsim_q  <= MIN_SIM_RST;
      ratio_q   <= RATIO_RST;
      mutual_q  <= MUTUAL_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_DESC_LEN: len_cfg_q <= cfg_data_i[LEN_CFG_W-1:0];
        CFG_MIN_SIM:  minsim_q  <= cfg_data_i[MINSIM_W-1:0];
        CFG_RATIO:    ratio_q   <= cfg_data_i[RATIO_W-1:0];
        CFG_MUTUAL:   mutual_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // run parameters and loop counters
  logic [CNT_W-1:0] na_q, nb_q, cnt_q;
  logic [LEN_W-1:0] len_q;
  logic [PT_W-1:0]  i_q, j_q;
  logic [ORD_W-1:0] ord_q;
  logic [WIDE_W-1:0] ca_w, cb_w;
  logic [8:0]        len_w;

  assign ca_w  = WIDE_W'(count_a_i);
  assign cb_w  = WIDE_W'(count_b_i);
  assign len_w = 9'(len_cfg_q);

  // dot-product engine
  logic                      busy_q, v1_q, v2_q, issue;
  logic [LEN_W-1:0]          k_q;
  logic signed [PROD_W-1:0]  p_q;
  logic signed [ACCX_W-1:0]  acc_q;
  logic signed [SIM_W-1:0]   sim;
  logic [A_AW-1:0]           dot_addr_a, dot_addr_b, load_addr;
  logic [ELEM_BITS-1:0]      a_rd, b_rd;
  logic                      load_ok;

  assign issue = busy_q && (k_q < len_q);
  assign sim   = acc_q[ACCX_W-1:15];
  assign dot_addr_a = A_AW'(i_q) * A_AW'(MAX_DESC_LEN) + A_AW'(k_q);
  assign dot_addr_b = A_AW'(j_q) * A_AW'(MAX_DESC_LEN) + A_AW'(k_q);
  assign load_addr  = A_AW'(point_index_i) * A_AW'(MAX_DESC_LEN) + A_AW'(elem_index_i);
  assign load_ok    = (WIDE_W'(point_index_i) < WIDE_W'(MAX_POINTS)) &&
                      (9'(elem_index_i) < 9'(MAX_DESC_LEN));

  mnd_ram #(.WIDTH(ELEM_BITS), .DEPTH(A_DEP)) u_set_a (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_a && load_ok),
    .waddr_i (load_addr),
    .wdata_i (elem_value_i[ELEM_BITS-1:0]),
    .raddr_i (dot_addr_a),
    .rdata_o (a_rd)
  );

  mnd_ram #(.WIDTH(ELEM_BITS), .DEPTH(A_DEP)) u_set_b (
    .clk_i   (clk_i),
    .we_i    (cmd_i.load_b && load_ok),
    .waddr_i (load_addr),
    .wdata_i (elem_value_i[ELEM_BITS-1:0]),
    .raddr_i (dot_addr_b),
    .rdata_o (b_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
    end else if (cmd_i.dot_start) begin
      busy_q <= 1'b1;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
      if (status_o.dot_done) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.dot_start) begin
      k_q   <= '0;
      acc_q <= '0;
    end else begin
      if (issue) k_q <= k_q + LEN_W'(1);
      if (v2_q) acc_q <= acc_q + {{(ACCX_W-PROD_W){p_q[PROD_W-1]}}, p_q};
    end
    p_q <= $signed(a_rd) * $signed(b_rd);
  end

  // scan registers
  logic signed [SIM_W-1:0] best_q, second_q, cbest_q;
  logic [PT_W-1:0]         bj_q, cbi_q;
  logic                    bj_v_q, cbi_v_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.row_init) begin
      best_q   <= SIM_NEG_ONE;
      second_q <= SIM_NEG_ONE;
      bj_v_q   <= 1'b0;
    end else if (cmd_i.row_cmp) begin
      if (sim > best_q) begin
        second_q <= best_q;
        best_q   <= sim;
        bj_q     <= j_q;
        bj_v_q   <= 1'b1;
      end else if (sim > second_q) begin
        second_q <= sim;
      end
    end
    if (cmd_i.col_init) begin
      cbest_q <= SIM_NEG_ONE;
      cbi_v_q <= 1'b0;
    end else if (cmd_i.col_cmp && (sim > cbest_q)) begin
      cbest_q <= sim;
      cbi_q   <= i_q;
      cbi_v_q <= 1'b1;
    end
  end

  // per-row and per-column result stores
  logic [ROW_W-1:0] row_rd;
  logic [COL_W-1:0] col_rd;

  mnd_ram #(.WIDTH(ROW_W), .DEPTH(MAX_POINTS)) u_row (
    .clk_i   (clk_i),
    .we_i    (cmd_i.row_wr),
    .waddr_i (i_q),
    .wdata_i ({bj_v_q, bj_q, best_q, second_q}),
    .raddr_i (i_q),
    .rdata_o (row_rd)
  );

  logic                    r_vld;
  logic [PT_W-1:0]         r_bj;
  logic signed [SIM_W-1:0] r_best, r_second;

  assign {r_vld, r_bj, r_best, r_second} = row_rd;

  mnd_ram #(.WIDTH(COL_W), .DEPTH(MAX_POINTS)) u_col (
    .clk_i   (clk_i),
    .we_i    (cmd_i.col_wr),
    .waddr_i (j_q),
    .wdata_i ({cbi_v_q, cbi_q}),
    .raddr_i (r_bj),
    .rdata_o (col_rd)
  );

  // match filter
  logic signed [RP_W-1:0]  rprod_q;
  logic signed [RP_W-1:0]  ss_scaled;
  logic signed [SIM_W-1:0] minsim_x;
  logic signed [SIM_W:0]   dist_x;
  logic [DIST_W-1:0]       dist_sat;
  logic                    keep;
  logic [MW-1:0]           m_rd;

  always_ff @(posedge clk_i) begin
    rprod_q <= RP_W'(r_best) * $signed({1'b0, ratio_q});
  end

  assign ss_scaled = RP_W'($signed({r_second, 15'b0}));
  assign minsim_x  = SIM_W'($signed(minsim_q));
  assign dist_x    = (SIM_W+1)'(32768) - (SIM_W+1)'(r_best);
  assign dist_sat  = dist_x[SIM_W] ? '0 : dist_x[DIST_W-1:0];
  assign keep = r_vld && !(r_best < minsim_x) &&
                ((ratio_q == '0) || !(rprod_q < ss_scaled)) &&
                (!mutual_q || (col_rd[PT_W] && (col_rd[PT_W-1:0] == i_q)));

  // the ordinal goes straight to the RAM on the accept edge so the data
  // is ready when the reply is loaded
  mnd_ram #(.WIDTH(MW), .DEPTH(MAX_POINTS)) u_match (
    .clk_i   (clk_i),
    .we_i    (cmd_i.fin_chk && keep),
    .waddr_i (cnt_q[PT_W-1:0]),
    .wdata_i ({i_q, r_bj, dist_sat}),
    .raddr_i (cmd_i.read_latch ? PT_W'(match_ordinal_i) : PT_W'(ord_q)),
    .rdata_o (m_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      na_q  <= '0;
      nb_q  <= '0;
    end else if (cmd_i.run_latch) begin
      cnt_q <= '0;
      na_q  <= CNT_W'((ca_w > WIDE_W'(MAX_POINTS)) ? WIDE_W'(MAX_POINTS) : ca_w);
      nb_q  <= CNT_W'((cb_w > WIDE_W'(MAX_POINTS)) ? WIDE_W'(MAX_POINTS) : cb_w);
    end else if (cmd_i.fin_chk && keep) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.run_latch) begin
      len_q <= LEN_W'((len_w > 9'(MAX_DESC_LEN)) ? 9'(MAX_DESC_LEN) : len_w);
    end
    if (cmd_i.read_latch) ord_q <= match_ordinal_i;
    if (cmd_i.clr_i) i_q <= '0;
    else if (cmd_i.inc_i) i_q <= i_q + PT_W'(1);
    if (cmd_i.clr_j) j_q <= '0;
    else if (cmd_i.inc_j) j_q <= j_q + PT_W'(1);
  end

  // output register
  logic                out_valid_q;
  logic                found;
  logic [PT_W-1:0]     m_row, m_col;
  logic [DIST_W-1:0]   m_dist;

  assign {m_row, m_col, m_dist} = m_rd;
  assign found = (WIDE_W'(ord_q) < WIDE_W'(cnt_q)) &&
                 (WIDE_W'(ord_q) < WIDE_W'(MAX_POINTS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.reply_run || cmd_i.reply_read) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.reply_run || cmd_i.reply_read) begin
      reply_kind_o  <= cmd_i.reply_read ? KIND_READ : KIND_RUN;
      match_total_o <= TOT_W'(cnt_q);
      found_o       <= cmd_i.reply_read && found;
      row_point_o   <= (cmd_i.reply_read && found) ? PT_IN_W'(m_row) : '0;
      col_point_o   <= (cmd_i.reply_read && found) ? PT_IN_W'(m_col) : '0;
      distance_o    <= (cmd_i.reply_read && found) ? m_dist : '0;
    end
  end

  assign out_valid_o = out_valid_q;

  assign status_o.dot_done = busy_q && !issue && !v1_q && !v2_q;
  assign status_o.i_last   = (CNT_W'(i_q) + CNT_W'(1)) == na_q;
  assign status_o.j_last   = (CNT_W'(j_q) + CNT_W'(1)) == nb_q;
  assign status_o.empty    = (na_q == '0) || (nb_q == '0);
  assign status_o.mutual   = mutual_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  a_reply_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.reply_run || cmd_i.reply_read) |=> out_valid_q)
    else $error("reply not presented");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= na_q)
    else $error("more matches than rows");

  a_row_store_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.row_wr || cmd_i.col_wr) |-> !busy_q)
    else $error("scan result stored with dot product in flight");

endmodule

// ===== rtl/core/mutual_nn_descriptor_matcher_top.sv =====
// Top level of the mutual nearest-neighbor descriptor matcher.
`timescale 1ns / 1ps
// Load request: no reply; loads stream at one per cycle while the controller is idle.
// Run request: a row scan, a column scan when the mutual check is on, and a
//   filter pass; the dot products come from the single multiply-accumulate
//   unit that reads one element pair a cycle from the two descriptor RAMs.
// Read request: replies from the match store. One request is worked on at a time.
// Reset clears the controller, match count and registers; descriptor and match
//   stores are not cleared (no clearing pass), loads must precede use.
module mutual_nn_descriptor_matcher_top #(
  parameter int MAX_POINTS   = 1024,
  parameter int MAX_DESC_LEN = 64,
  parameter int ELEM_BITS    = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [mnd_pkg::REQ_W-1:0]      req_type_i,
  input  logic [mnd_pkg::PT_IN_W-1:0]    point_index_i,
  input  logic [mnd_pkg::EL_IN_W-1:0]    elem_index_i,
  input  logic [mnd_pkg::VAL_W-1:0]      elem_value_i,
  input  logic [mnd_pkg::CNT_IN_W-1:0]   count_a_i,
  input  logic [mnd_pkg::CNT_IN_W-1:0]   count_b_i,
  input  logic [mnd_pkg::ORD_W-1:0]      match_ordinal_i,
  // reply channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           reply_kind_o,
  output logic [mnd_pkg::TOT_W-1:0]      match_total_o,
  output logic                           found_o,
  output logic [mnd_pkg::PT_IN_W-1:0]    row_point_o,
  output logic [mnd_pkg::PT_IN_W-1:0]    col_point_o,
  output logic [mnd_pkg::DIST_W-1:0]     distance_o,
  // configuration writes
  input  logic                           cfg_we_i,
  input  logic [mnd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mnd_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import mnd_pkg::*;

  mnd_cmd_t    cmd;
  mnd_status_t status;

  // controller: takes requests only when idle; the reply sits in the
  // datapath output register so loads keep flowing while it waits
  mnd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // datapath: stores, dot-product pipe (read, multiply, accumulate),
  // best/second tracking, ratio/mutual filter and the reply register
  mnd_dp #(
    .MAX_POINTS   (MAX_POINTS),
    .MAX_DESC_LEN (MAX_DESC_LEN),
    .ELEM_BITS    (ELEM_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .point_index_i   (point_index_i),
    .elem_index_i    (elem_index_i),
    .elem_value_i    (elem_value_i),
    .count_a_i       (count_a_i),
    .count_b_i       (count_b_i),
    .match_ordinal_i (match_ordinal_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .reply_kind_o    (reply_kind_o),
    .match_total_o   (match_total_o),
    .found_o         (found_o),
    .row_point_o     (row_point_o),
    .col_point_o     (col_point_o),
    .distance_o      (distance_o)
  );

endmodule
